// ===== src/i2ie_pkg.sv =====
// ----------------------------------------------------------------------------
// i2ie_pkg
// Shared types and constants for the IBM hex float to IEEE single converter.
// ----------------------------------------------------------------------------
package i2ie_pkg;

  // input item: raw file word plus last-word marker
  typedef struct packed {
    logic [31:0] raw_word;
    logic        is_last;
  } in_item_t;

  // result item: converted or passthrough word plus marker copy
  typedef struct packed {
    logic [31:0] ieee_word;
    logic        is_last_out;
  } out_item_t;

  // configuration port geometry
  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam logic        CFG_IDX_CONVERT_ENABLE = 1'b0;

  // hex float fraction width and working widths for shift and exponent
  localparam int unsigned FRAC_W  = 24;
  localparam int unsigned SHIFT_W = 5;
  localparam int unsigned EXPO_W  = 10;

  // conversion constants
  localparam logic signed [EXPO_W-1:0] EXPO_ADJ  = 10'sd130;
  localparam logic signed [EXPO_W-1:0] EXPO_MAX  = 10'sd254;
  localparam logic [30:0]              MAX_FINITE = 31'h7f7fffff;

endpackage

// ===== src/i2ie_norm.sv =====
// ----------------------------------------------------------------------------
// i2ie_norm
// Normalizes a non-zero 24-bit fraction with a five-step binary shifter and
// reports the total left shift applied.
// ----------------------------------------------------------------------------
module i2ie_norm (
  input  logic [i2ie_pkg::FRAC_W-1:0]  frac_in,
  output logic [i2ie_pkg::FRAC_W-1:0]  frac_out,
  output logic [i2ie_pkg::SHIFT_W-1:0] shift
);
  import i2ie_pkg::*;

  logic [FRAC_W-1:0] f16, f8, f4, f2, f1;
  logic              s16, s8, s4, s2, s1;

  // coarse to fine: each step shifts when the top slice is all zero
  always_comb begin
    s16 = (frac_in[23:8] == 16'd0);
    f16 = s16 ? {frac_in[7:0], 16'd0} : frac_in;
    s8  = (f16[23:16] == 8'd0);
    f8  = s8 ? {f16[15:0], 8'd0} : f16;
    s4  = (f8[23:20] == 4'd0);
    f4  = s4 ? {f8[19:0], 4'd0} : f8;
    s2  = (f4[23:22] == 2'd0);
    f2  = s2 ? {f4[21:0], 2'd0} : f4;
    s1  = ~f2[23];
    f1  = s1 ? {f2[22:0], 1'b0} : f2;
  end

  assign frac_out = f1;
  assign shift    = {s16, s8, s4, s2, s1};

endmodule

// ===== src/i2ie_conv.sv =====
// ----------------------------------------------------------------------------
// i2ie_conv
// Byte swap and IBM hex float to IEEE single re-encoding, with saturation on
// exponent overflow and flush to +0 on underflow; raw passthrough when disabled.
// ----------------------------------------------------------------------------
module i2ie_conv (
  input  logic        convert_enable,
  input  logic [31:0] word_in,
  output logic [31:0] word_out
);
  import i2ie_pkg::*;

  logic [31:0]              swapped;
  logic [FRAC_W-1:0]        frac;
  logic [FRAC_W-1:0]        frac_n;
  logic [SHIFT_W-1:0]       shift;
  logic signed [EXPO_W-1:0] expo;
  logic [31:0]              conv;

  // reverse byte order of the file word
  assign swapped = {word_in[7:0], word_in[15:8], word_in[23:16], word_in[31:24]};
  assign frac    = swapped[FRAC_W-1:0];

  i2ie_norm u_norm (
    .frac_in  (frac),
    .frac_out (frac_n),
    .shift    (shift)
  );

  // biased exponent: 4 * exp7 - 130 - shift
  assign expo = $signed({1'b0, swapped[30:24], 2'b00}) - EXPO_ADJ
              - $signed({{(EXPO_W-SHIFT_W){1'b0}}, shift});

  // special cases then normal re-encoding
  always_comb begin
    if (frac == '0) begin
      conv = swapped;
    end else if (expo > EXPO_MAX) begin
      conv = {swapped[31], MAX_FINITE};
    end else if (expo <= 10'sd0) begin
      conv = 32'd0;
    end else begin
      conv = {swapped[31], expo[7:0], frac_n[22:0]};
    end
  end

  assign word_out = convert_enable ? conv : word_in;

endmodule

// ===== src/i2ie_cfg.sv =====
// ----------------------------------------------------------------------------
// i2ie_cfg
// APB-style register block holding the convert enable bit.
// ----------------------------------------------------------------------------
module i2ie_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [i2ie_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [i2ie_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [i2ie_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  output logic                            convert_enable
);
  import i2ie_pkg::*;

  logic convert_enable_r, convert_enable_nxt;
  logic wr_en;
  logic sel_conv;

  // register index is the word address
  assign sel_conv = (paddr[2] == CFG_IDX_CONVERT_ENABLE);
  assign wr_en    = psel & penable & pwrite & pready;

  always_comb begin
    convert_enable_nxt = convert_enable_r;
    if (wr_en && sel_conv) begin
      convert_enable_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      convert_enable_r <= 1'b0;
    end else begin
      convert_enable_r <= convert_enable_nxt;
    end
  end

  // read back
  assign prdata = sel_conv ? {{(CFG_DATA_W-1){1'b0}}, convert_enable_r} : '0;
  assign pready = 1'b1;
  assign convert_enable = convert_enable_r;

endmodule

// ===== src/ibm_to_ieee_float_converter_top.sv =====
// path: an accepted item is captured in the input register, converted combinationally
//   and registered in the result register that drives out_item
// throughput: one item per cycle; busy stays low, the input register and the
//   result register each take a new item every cycle
// the result strobe lasts one cycle and the receiver cannot stall it
// reset (rst_n, synchronous): clears item valid flags and convert_enable to 0
// ----------------------------------------------------------------------------
// ibm_to_ieee_float_converter_top
// Streams 32-bit file words through an optional byte swap and IBM hex float
// to IEEE single conversion, one item per clock.
// ----------------------------------------------------------------------------
module ibm_to_ieee_float_converter_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  i2ie_pkg::in_item_t              in_item,
  output logic                            out_valid,
  output i2ie_pkg::out_item_t             out_item,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [i2ie_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [i2ie_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [i2ie_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import i2ie_pkg::*;

  logic        convert_enable;
  logic        in_valid_r, in_valid_nxt;
  in_item_t    in_item_r;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_item_r, out_item_nxt;
  logic [31:0] conv_word;

  i2ie_cfg u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .convert_enable (convert_enable)
  );

  // never stalls
  assign busy = 1'b0;

  // input register
  assign in_valid_nxt = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_nxt) begin
      in_item_r <= in_item;
    end
  end

  i2ie_conv u_conv (
    .convert_enable (convert_enable),
    .word_in        (in_item_r.raw_word),
    .word_out       (conv_word)
  );

  // result register
  assign out_valid_nxt            = in_valid_r;
  assign out_item_nxt.ieee_word   = conv_word;
  assign out_item_nxt.is_last_out = in_item_r.is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // every accepted item yields exactly one strobe
  a_two_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("accepted item did not produce a result");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_valid_r))
    else $error("result strobe without a captured item");

  // marker follows its word
  a_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.is_last_out == $past(in_item_r.is_last))
    else $error("last marker out of step with its word");

  // passthrough when conversion is off
  a_passthru: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !$past(convert_enable)) |-> out_item.ieee_word == $past(in_item_r.raw_word))
    else $error("passthrough word altered");

  // a converted non-zero fraction never encodes infinity or nan
  a_finite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(convert_enable) && $past(in_item_r.raw_word[31:8] != 24'd0))
      |-> out_item.ieee_word[30:23] != 8'hff)
    else $error("converted result is not finite");

endmodule

// ===== verif/ibm_to_ieee_float_converter_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibm_to_ieee_float_converter_top_tb
// Drives file words through the converter with conversion switched on and off
// over the APB port, predicts or looks up every result item and checks it field by field.
// A short table of corner words comes first, then random words in three idle
// profiles on the sender side.
// ----------------------------------------------------------------------------
module ibm_to_ieee_float_converter_top_tb;
  import i2ie_pkg::*;

  localparam int          CLK_HALF     = 5;
  localparam int          DRAIN_CYCLES = 6;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          SEG_ITEMS    = 283;
  localparam int          N_SEGMENTS   = 6;
  localparam int          HEX_BIAS_ADJ = 130;
  localparam int          IEEE_EXP_MAX = 254;
  localparam logic [31:0] SIGN_MASK    = 32'h8000_0000;
  localparam logic [31:0] MANT_MASK    = 32'h007f_ffff;
  localparam logic [CFG_ADDR_W-1:0] ADDR_CONVERT_ENABLE = CFG_ADDR_W'(4 * CFG_IDX_CONVERT_ENABLE);

  localparam logic CONV_OFF  = 1'b0;
  localparam logic CONV_ON   = 1'b1;
  localparam logic PREDICTED = 1'b0;
  localparam logic TYPED     = 1'b1;

  // one row of the corner table
  typedef struct packed {
    logic        en;
    logic [31:0] raw;
    logic        last;
    logic        typed;
    logic [31:0] ieee;
  } vector_t;

  localparam int N_DIRECTED = 19;
  localparam vector_t DIRECTED_VECTORS [N_DIRECTED] = '{
    // passthrough right after reset
    '{CONV_OFF, 32'h0000_0000, 1'b0, TYPED,     32'h0000_0000},
    '{CONV_OFF, 32'hffff_ffff, 1'b1, TYPED,     32'hffff_ffff},
    '{CONV_OFF, 32'h1234_5678, 1'b0, TYPED,     32'h1234_5678},
    // zero word
    '{CONV_ON,  32'h0000_0000, 1'b1, TYPED,     32'h0000_0000},
    // overflow saturates, sign kept
    '{CONV_ON,  32'hffff_ffff, 1'b0, TYPED,     32'hff7f_ffff},
    '{CONV_ON,  32'hffff_ff7f, 1'b1, TYPED,     32'h7f7f_ffff},
    // zero fraction with other bits set passes swapped
    '{CONV_ON,  32'h0000_0041, 1'b0, TYPED,     32'h4100_0000},
    '{CONV_ON,  32'h0000_0080, 1'b0, TYPED,     32'h8000_0000},
    // plus and minus one
    '{CONV_ON,  32'h0000_1041, 1'b0, TYPED,     32'h3f80_0000},
    '{CONV_ON,  32'h0000_10c1, 1'b1, TYPED,     32'hbf80_0000},
    // underflow flushes to plus zero
    '{CONV_ON,  32'h0100_0000, 1'b0, TYPED,     32'h0000_0000},
    '{CONV_ON,  32'h0100_0080, 1'b0, TYPED,     32'h0000_0000},
    // exponent edges
    '{CONV_ON,  32'h0000_4021, 1'b0, PREDICTED, 32'h0000_0000},
    '{CONV_ON,  32'h0000_2021, 1'b0, PREDICTED, 32'h0000_0000},
    '{CONV_ON,  32'h0000_8060, 1'b0, PREDICTED, 32'h0000_0000},
    '{CONV_ON,  32'h0000_1061, 1'b0, PREDICTED, 32'h0000_0000},
    '{CONV_ON,  32'hffff_ff40, 1'b1, PREDICTED, 32'h0000_0000},
    '{CONV_ON,  32'h0000_80e0, 1'b0, PREDICTED, 32'h0000_0000},
    // back to passthrough
    '{CONV_OFF, 32'ha5a5_a5a5, 1'b1, TYPED,     32'ha5a5_a5a5}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_item_t              in_item;
  logic                  out_valid;
  out_item_t             out_item;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  out_item_t ieee_items_due[$];
  out_item_t head_item;
  logic      conv_on;
  int        idle_pct;
  int        fail_count;
  int        cycle_count;

  ibm_to_ieee_float_converter_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  function automatic logic [31:0] swap_bytes(logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  // expected result of one item under the given conversion setting
  function automatic out_item_t predict_ieee_item(in_item_t it, logic en);
    out_item_t   res;
    logic [31:0] w;
    logic [31:0] frac;
    logic [31:0] sign;
    int          expo;
    w = it.raw_word;
    if (en) begin
      w    = swap_bytes(w);
      frac = {8'h00, w[23:0]};
      sign = w & SIGN_MASK;
      if (frac != 0) begin
        expo = 4 * int'(w[30:24]) - HEX_BIAS_ADJ;
        while (!frac[23]) begin
          expo--;
          frac = frac << 1;
        end
        if (expo > IEEE_EXP_MAX)
          w = sign | {1'b0, MAX_FINITE};
        else if (expo <= 0)
          w = 32'h0;
        else
          w = sign | (32'(expo) << 23) | (frac & MANT_MASK);
      end
    end
    res.ieee_word   = w;
    res.is_last_out = it.is_last;
    return res;
  endfunction

  // random hex float word, biased toward normal values and exponent edges
  function automatic logic [31:0] random_ibm_word();
    logic [23:0] frac;
    logic [6:0]  exp7;
    int          pick;
    pick = $urandom_range(0, 99);
    frac = 24'($urandom) >> $urandom_range(0, 23);
    if (frac == 0)
      frac = 24'h1;
    exp7 = 7'($urandom);
    if (pick < 25)
      return $urandom;
    else if (pick < 35)
      return {1'($urandom), 7'($urandom), 24'h0};
    else if (pick < 50)
      exp7 = $urandom_range(0, 1) ? 7'($urandom_range(30, 34)) : 7'($urandom_range(94, 98));
    return {1'($urandom), exp7, frac};
  endfunction

  // hand one item to the block, then idle at random
  task automatic send_item(in_item_t it, logic typed, logic [31:0] typed_word);
    out_item_t due;
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    due = predict_ieee_item(it, conv_on);
    if (typed)
      due.ieee_word = typed_word;
    ieee_items_due.push_back(due);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
  endtask

  // write convert_enable once the block is idle, then read it back
  task automatic set_convert_enable(logic en);
    start <= 1'b0;
    while (ieee_items_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_CONVERT_ENABLE;
    pwdata  <= CFG_DATA_W'(en);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    conv_on = en;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== CFG_DATA_W'(conv_on)) begin
      $error("convert_enable readback: expected %0h, actual %0h", conv_on, prdata);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (ieee_items_due.size() == 0) begin
        $error("unexpected item: ieee_word %h is_last_out %b",
               out_item.ieee_word, out_item.is_last_out);
        fail_count++;
      end else begin
        head_item = ieee_items_due.pop_front();
        if (out_item.ieee_word !== head_item.ieee_word) begin
          $error("ieee_word: expected %h, actual %h", head_item.ieee_word, out_item.ieee_word);
          fail_count++;
        end
        if (out_item.is_last_out !== head_item.is_last_out) begin
          $error("is_last_out: expected %b, actual %b",
                 head_item.is_last_out, out_item.is_last_out);
          fail_count++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // stimulus
  initial begin
    in_item_t it;
    logic     seg_en;
    fail_count  = 0;
    cycle_count = 0;
    conv_on     = CONV_OFF;
    idle_pct    = 9;
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_item <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corner table
    for (int i = 0; i < N_DIRECTED; i++) begin
      if (DIRECTED_VECTORS[i].en != conv_on)
        set_convert_enable(DIRECTED_VECTORS[i].en);
      it.raw_word = DIRECTED_VECTORS[i].raw;
      it.is_last  = DIRECTED_VECTORS[i].last;
      send_item(it, DIRECTED_VECTORS[i].typed, DIRECTED_VECTORS[i].ieee);
    end

    // random words: two setting segments per idle profile
    for (int seg = 0; seg < N_SEGMENTS; seg++) begin
      idle_pct = (seg < 2) ? 9 : (seg < 4) ? 67 : 0;
      seg_en   = (seg % 3 != 1) ? CONV_ON : CONV_OFF;
      if (seg_en != conv_on)
        set_convert_enable(seg_en);
      for (int n = 0; n < SEG_ITEMS; n++) begin
        it.raw_word = swap_bytes(random_ibm_word());
        it.is_last  = ($urandom_range(0, 7) == 0);
        send_item(it, PREDICTED, 32'h0);
      end
    end

    // drain
    start <= 1'b0;
    while (ieee_items_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
